@@ rtl/afbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the adaptive filter band selector.
// No dependencies; imported by every module of the block.
package afbs_pkg;

    localparam int RATE_W    = 20;
    localparam int TIME_W    = 48;
    localparam int SUM_W     = 40;
    localparam int MAG_W     = 20;
    localparam int REM_W     = MAG_W + 2;
    localparam int LP_W      = 40;
    localparam int LP_EXTRA  = 16;
    localparam int GAIN_W    = 16;
    localparam int THR_W     = 20;
    localparam int CODE_W    = 3;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 5;

    localparam int TIME_BITS_DEF = 48;

    localparam logic [THR_W-1:0]  STATIC_TH_RST = THR_W'(1280);
    localparam logic [THR_W-1:0]  FAST_TH_RST   = THR_W'(25600);
    localparam logic [TIME_W-1:0] COOLDOWN_RST  = TIME_W'(24000000);
    localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(131);
    localparam logic [CODE_W-1:0] CODE_STATIC_RST  = CODE_W'(4);
    localparam logic [CODE_W-1:0] CODE_NORMAL_RST  = CODE_W'(3);
    localparam logic [CODE_W-1:0] CODE_FAST_RST    = CODE_W'(0);
    localparam logic [CODE_W-1:0] CODE_INITIAL_RST = CODE_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATIC_TH    = 3'd0,
        CFG_FAST_TH      = 3'd1,
        CFG_COOLDOWN     = 3'd2,
        CFG_GAIN         = 3'd3,
        CFG_CODE_STATIC  = 3'd4,
        CFG_CODE_NORMAL  = 3'd5,
        CFG_CODE_FAST    = 3'd6,
        CFG_CODE_INITIAL = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
        logic [TIME_W-1:0]        time_now;
    } in_item_t;

    typedef struct packed {
        logic              switch_now;
        logic [CODE_W-1:0] band_code;
        logic [MAG_W-1:0]  filtered_rate;
    } out_item_t;

    // Status of one serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

@@ rtl/afbs_sumsq.sv @@
`timescale 1ns / 1ps
// Bit-serial sum of squares of the three rate axes, one multiplier bit per cycle.
// Depends on afbs_pkg.
module afbs_sumsq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [afbs_pkg::RATE_W-1:0]  rate_x,
    input  logic signed [afbs_pkg::RATE_W-1:0]  rate_y,
    input  logic signed [afbs_pkg::RATE_W-1:0]  rate_z,
    output afbs_pkg::unit_stat_t                stat,
    output logic [afbs_pkg::SUM_W-1:0]          sum
);
    import afbs_pkg::*;

    logic [RATE_W-1:0] mx_reg, my_reg, mz_reg;
    logic [RATE_W-1:0] bx_reg, by_reg, bz_reg;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [RATE_W-1:0] ax, ay, az;

    assign ax = rate_x[RATE_W-1] ? (~rate_x + 1'b1) : rate_x;
    assign ay = rate_y[RATE_W-1] ? (~rate_y + 1'b1) : rate_y;
    assign az = rate_z[RATE_W-1] ? (~rate_z + 1'b1) : rate_z;

    // Horner form, MSB first: acc = 2*acc + bit * multiplicand on each lane
    always_comb
    begin
        acc_next = {acc_reg[SUM_W-2:0], 1'b0}
                 + SUM_W'(bx_reg[RATE_W-1] ? mx_reg : '0)
                 + SUM_W'(by_reg[RATE_W-1] ? my_reg : '0)
                 + SUM_W'(bz_reg[RATE_W-1] ? mz_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(RATE_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mx_reg  <= ax;
            my_reg  <= ay;
            mz_reg  <= az;
            bx_reg  <= ax;
            by_reg  <= ay;
            bz_reg  <= az;
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            bx_reg  <= {bx_reg[RATE_W-2:0], 1'b0};
            by_reg  <= {by_reg[RATE_W-2:0], 1'b0};
            bz_reg  <= {bz_reg[RATE_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign sum       = acc_reg;

endmodule

@@ rtl/afbs_isqrt.sv @@
`timescale 1ns / 1ps
// Digit-by-digit floor square root, one root bit (two radicand bits) per cycle.
// Depends on afbs_pkg.
module afbs_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [afbs_pkg::SUM_W-1:0]  radicand,
    output afbs_pkg::unit_stat_t        stat,
    output logic [afbs_pkg::MAG_W-1:0]  root
);
    import afbs_pkg::*;

    logic [SUM_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [MAG_W-1:0]   root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [REM_W+1:0]   cand, trial, delta;
    logic               ge;

    always_comb
    begin
        cand  = {rem_reg, rad_reg[SUM_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        delta = cand - trial;
        ge    = (cand >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(MAG_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            // keep the trial difference when it fits, else hold the shifted remainder
            rem_reg  <= ge ? delta[REM_W-1:0] : cand[REM_W-1:0];
            root_reg <= {root_reg[MAG_W-2:0], ge};
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

@@ rtl/afbs_lowpass.sv @@
`timescale 1ns / 1ps
// Low-pass state with a bit-serial gain multiply: lp += floor(gain * (mag<<16 - lp) / 2^16).
// Depends on afbs_pkg.
module afbs_lowpass (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [afbs_pkg::MAG_W-1:0]   mag,
    input  logic [afbs_pkg::GAIN_W-1:0]  gain,
    output afbs_pkg::unit_stat_t         stat,
    output logic [afbs_pkg::LP_W-1:0]    lp
);
    import afbs_pkg::*;

    localparam int DIFF_W = LP_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W;

    logic [LP_W-1:0]          lp_reg, lp_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [DIFF_W-1:0]        diff_next;
    logic [GAIN_W-1:0]        g_reg;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     upd_reg;
    logic                     done_reg;
    logic [DIFF_W-1:0]        step;

    always_comb
    begin
        diff_next = {{(DIFF_W-MAG_W-LP_EXTRA){1'b0}}, mag, {LP_EXTRA{1'b0}}}
                  - {1'b0, lp_reg};
        acc_next  = {acc_reg[PROD_W-2:0], 1'b0}
                  + (g_reg[GAIN_W-1] ? {{GAIN_W{diff_reg[DIFF_W-1]}}, diff_reg}
                                     : PROD_W'(0));
        // arithmetic shift right by the fraction bits gives the floor
        step      = acc_reg[PROD_W-1:LP_EXTRA];
        lp_next   = lp_reg + step[LP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg   <= '0;
            cnt_reg  <= '0;
            upd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            upd_reg  <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(GAIN_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    upd_reg <= 1'b1;
                end
            end
            if (upd_reg)
            begin
                lp_reg   <= lp_next;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            diff_reg <= $signed(diff_next);
            g_reg    <= gain;
            acc_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            g_reg   <= {g_reg[GAIN_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = (cnt_reg != '0) || upd_reg;
    assign stat.done = done_reg;
    assign lp        = lp_reg;

endmodule

@@ rtl/adaptive_filter_band_selector.sv @@
`timescale 1ns / 1ps
// Top level of the adaptive filter band selector: configuration, sequencing, band decision.
// Depends on afbs_pkg, afbs_sumsq, afbs_isqrt and afbs_lowpass.
//
// Usage:
//   in_valid/in_ready/in_data carry one gyro sample (three signed Q.8 rates and a
//   timestamp). out_valid/out_ready/out_data carry exactly one result per sample:
//   switch flag, band code in force, integer part of the smoothed magnitude.
//   cfg_we/cfg_index/cfg_data write one register per cycle, no wait; write only
//   while the block is idle. A code_initial write is ignored; reset loads the default.
//   From input transfer to out_valid a sample passes through serial squaring
//   (one multiplier bit per cycle), the square root (one root bit per cycle),
//   the serial gain multiply with a registered filter update, and the decision
//   step. One sample is in flight at a time, so a new sample is taken only once
//   the last result has left the decision step.
//   A finished result sits in the output register; in_ready returns while it
//   waits. If the receiver stalls, the next result holds in the decision step
//   until the output register frees.
//   Reset (rst_n, asynchronous, active low) clears the filter state and the
//   last switch time, loads the register defaults and sets the initial band.
module adaptive_filter_band_selector #(
    parameter int TIME_BITS = afbs_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  afbs_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output afbs_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [afbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afbs_pkg::CFG_W-1:0]      cfg_data
);
    import afbs_pkg::*;

    localparam int CMP_W = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SUMSQ  = 5'b00010,
        ST_SQRT   = 5'b00100,
        ST_FILT   = 5'b01000,
        ST_DECIDE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [THR_W-1:0]     static_th_reg, fast_th_reg;
    logic [TIME_W-1:0]    cooldown_reg;
    logic [GAIN_W-1:0]    gain_reg;
    logic [CODE_W-1:0]    code_static_reg, code_normal_reg, code_fast_reg;
    logic [CODE_W-1:0]    band_reg;
    logic [TIME_BITS-1:0] last_reg;
    logic [TIME_W-1:0]    time_reg;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    unit_stat_t           sq_stat, rt_stat, lp_stat;
    logic [SUM_W-1:0]     sum;
    logic [MAG_W-1:0]     mag;
    logic [LP_W-1:0]      lp;

    logic                 in_xfer;
    logic                 out_load;
    logic [TIME_BITS-1:0] now_t, elapsed;
    logic                 cool_ok;
    logic [CODE_W-1:0]    target;
    logic                 sw;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == ST_DECIDE) && (!out_valid_reg || out_ready);

    afbs_sumsq u_sumsq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_xfer),
        .rate_x (in_data.rate_x),
        .rate_y (in_data.rate_y),
        .rate_z (in_data.rate_z),
        .stat   (sq_stat),
        .sum    (sum)
    );

    afbs_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_stat.done),
        .radicand (sum),
        .stat     (rt_stat),
        .root     (mag)
    );

    afbs_lowpass u_lowpass (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rt_stat.done),
        .mag   (mag),
        .gain  (gain_reg),
        .stat  (lp_stat),
        .lp    (lp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_xfer)      state_next = ST_SUMSQ;
            ST_SUMSQ:  if (sq_stat.done) state_next = ST_SQRT;
            ST_SQRT:   if (rt_stat.done) state_next = ST_FILT;
            ST_FILT:   if (lp_stat.done) state_next = ST_DECIDE;
            ST_DECIDE: if (out_load)     state_next = ST_IDLE;
            default:                     state_next = ST_IDLE;
        endcase
    end

    // Band decision on the freshly updated filter value
    always_comb
    begin
        now_t   = TIME_BITS'(time_reg);
        elapsed = now_t - last_reg;
        cool_ok = (CMP_W'(elapsed) >= CMP_W'(cooldown_reg));
        if (lp < {{(LP_W-THR_W-LP_EXTRA){1'b0}}, static_th_reg, {LP_EXTRA{1'b0}}})
        begin
            target = code_static_reg;
        end
        else if (lp > {{(LP_W-THR_W-LP_EXTRA){1'b0}}, fast_th_reg, {LP_EXTRA{1'b0}}})
        begin
            target = code_fast_reg;
        end
        else
        begin
            target = code_normal_reg;
        end
        sw = cool_ok && (target != band_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            static_th_reg   <= STATIC_TH_RST;
            fast_th_reg     <= FAST_TH_RST;
            cooldown_reg    <= COOLDOWN_RST;
            gain_reg        <= GAIN_RST;
            code_static_reg <= CODE_STATIC_RST;
            code_normal_reg <= CODE_NORMAL_RST;
            code_fast_reg   <= CODE_FAST_RST;
            band_reg        <= CODE_INITIAL_RST;
            last_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STATIC_TH:   static_th_reg   <= cfg_data[THR_W-1:0];
                    CFG_FAST_TH:     fast_th_reg     <= cfg_data[THR_W-1:0];
                    CFG_COOLDOWN:    cooldown_reg    <= cfg_data[TIME_W-1:0];
                    CFG_GAIN:        gain_reg        <= cfg_data[GAIN_W-1:0];
                    CFG_CODE_STATIC: code_static_reg <= cfg_data[CODE_W-1:0];
                    CFG_CODE_NORMAL: code_normal_reg <= cfg_data[CODE_W-1:0];
                    CFG_CODE_FAST:   code_fast_reg   <= cfg_data[CODE_W-1:0];
                    // the initial band is only loaded by reset, which also restores
                    // its default, so a write here never becomes visible
                    CFG_CODE_INITIAL: ;
                    default: ;
                endcase
            end
            if (out_load && sw)
            begin
                band_reg <= target;
                last_reg <= now_t;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            time_reg <= in_data.time_now;
        end
        if (out_load)
        begin
            out_data_reg.switch_now    <= sw;
            out_data_reg.band_code     <= sw ? target : band_reg;
            out_data_reg.filtered_rate <= lp[LP_EXTRA +: MAG_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_start_sumsq: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> sq_stat.busy)
        else $error("squarer did not start after input transfer");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({sq_stat.busy, rt_stat.busy, lp_stat.busy}))
        else $error("more than one serial unit busy");

    a_lp_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        lp_stat.done |-> (state_reg == ST_FILT))
        else $error("filter update finished outside the filter step");

    a_switch_changes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && sw) |=> (band_reg != $past(band_reg)))
        else $error("switch flagged without a band change");

    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(sq_stat.busy || rt_stat.busy || lp_stat.busy))
        else $error("serial unit busy while idle");
`endif

endmodule
